/* sv/multi_pattern_key_sequence_matcher_unit_assert.svh */
// assertion macros used by the key sequence matcher controller
`ifndef MULTI_PATTERN_KEY_SEQUENCE_MATCHER_UNIT_ASSERT_SVH
`define MULTI_PATTERN_KEY_SEQUENCE_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MPKSM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MPKSM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mpksm_pkg.sv */
// types, constants and command codes of the key sequence matcher
package mpksm_pkg;

	localparam int NUM_ENTRIES     = 16;
	localparam int MAX_PATTERN_LEN = 32;
	localparam int CAPTURE_BYTES   = 8;

	localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
	localparam int POS_W  = $clog2(MAX_PATTERN_LEN);
	localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
	localparam int FILL_W = $clog2(CAPTURE_BYTES + 1);
	localparam int CAP_IDX_W = (CAPTURE_BYTES > 1) ? $clog2(CAPTURE_BYTES) : 1;
	localparam int PAT_ADDR_W = IDX_W + POS_W;
	localparam int PAT_DEPTH  = NUM_ENTRIES << POS_W;

	localparam int PADDR_W = 3;

	localparam logic [7:0] WILDCARD = 8'h2E;

	// register indexes on the configuration port
	localparam logic REG_GAME_MASK  = 1'b0;
	localparam logic REG_ALL_ENABLE = 1'b1;

	typedef enum logic [1:0] {
		CMD_KEY   = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_ATTR  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_ACK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic             load_in;
		logic             table_wr;
		logic             issue;
		logic [IDX_W-1:0] issue_idx;
		logic             cmp;
		logic [IDX_W-1:0] cmp_idx;
		logic             ack;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_key;
		logic fire;
		logic out_full;
	} dp_sts_t;

endpackage

/* sv/mpksm_ram.sv */
// simple dual-port ram with registered read data
module mpksm_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/mpksm_ctrl.sv */
// controller: item sequencing and the two-stage entry scan
`include "multi_pattern_key_sequence_matcher_unit_assert.svh"

module mpksm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mpksm_pkg::dp_sts_t  sts,
	output mpksm_pkg::dp_cmd_t  cmd
);

	mpksm_pkg::state_t state_q, state_nxt;

	logic [mpksm_pkg::CNT_W-1:0] rd_cnt_q;
	logic                        cmp_vld_s1;
	logic [mpksm_pkg::IDX_W-1:0] cmp_idx_s1;

	logic rd_done;
	logic stall;
	logic issue;
	logic cmp;

	// scan stage control
	assign rd_done = (rd_cnt_q == mpksm_pkg::CNT_W'(mpksm_pkg::NUM_ENTRIES));
	assign stall   = cmp_vld_s1 && sts.fire && sts.out_full;
	assign issue   = (state_q == mpksm_pkg::ST_SCAN) && !rd_done && !stall;
	assign cmp     = (state_q == mpksm_pkg::ST_SCAN) && cmp_vld_s1 && !stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mpksm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = mpksm_pkg::ST_DECODE;
				end
			end
			mpksm_pkg::ST_DECODE: begin
				state_nxt = sts.is_key ? mpksm_pkg::ST_SCAN : mpksm_pkg::ST_ACK;
			end
			mpksm_pkg::ST_SCAN: begin
				if (rd_done && (!cmp_vld_s1 || cmp)) begin
					state_nxt = mpksm_pkg::ST_ACK;
				end
			end
			mpksm_pkg::ST_ACK: begin
				if (!sts.out_full) begin
					state_nxt = mpksm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mpksm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.issue     = issue;
		cmd.issue_idx = rd_cnt_q[mpksm_pkg::IDX_W-1:0];
		cmd.cmp       = cmp;
		cmd.cmp_idx   = cmp_idx_s1;
		unique case (state_q)
			mpksm_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			mpksm_pkg::ST_DECODE: begin
				cmd.table_wr = !sts.is_key;
			end
			mpksm_pkg::ST_SCAN: begin
			end
			mpksm_pkg::ST_ACK: begin
				cmd.ack = !sts.out_full;
			end
			default: begin
			end
		endcase
	end

	// state and scan pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mpksm_pkg::ST_IDLE;
			rd_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == mpksm_pkg::ST_DECODE) begin
				rd_cnt_q   <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if ((state_q == mpksm_pkg::ST_SCAN) && !stall) begin
				cmp_vld_s1 <= issue;
				cmp_idx_s1 <= rd_cnt_q[mpksm_pkg::IDX_W-1:0];
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
			end
		end
	end

	`MPKSM_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state_q == mpksm_pkg::ST_DECODE, "accepted item not decoded")
	`MPKSM_ASSERT_IMP(a_ack_drained, state_q == mpksm_pkg::ST_ACK, !cmp_vld_s1, "final result while compare stage busy")
	`MPKSM_ASSERT_NXT(a_stall_holds, stall, cmp_vld_s1 && $stable(cmp_idx_s1), "stalled compare stage moved")
	`MPKSM_ASSERT_IMP(a_cnt_bound, state_q == mpksm_pkg::ST_SCAN, rd_cnt_q <= mpksm_pkg::CNT_W'(mpksm_pkg::NUM_ENTRIES), "scan counter past last entry")

endmodule

/* sv/mpksm_dp.sv */
// datapath: entry table, pattern memory, capture buffer and result register
module mpksm_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mpksm_pkg::dp_cmd_t  cmd,
	output mpksm_pkg::dp_sts_t  sts,
	input  logic [1:0]          command,
	input  logic [7:0]          key_or_byte,
	input  logic [3:0]          entry_index,
	input  logic [4:0]          byte_index,
	input  logic [5:0]          entry_length,
	input  logic [7:0]          entry_games,
	input  logic                entry_any_game,
	input  logic [7:0]          game_mask,
	input  logic                all_enable,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [3:0]          fired_index,
	output logic [3:0]          arg_count,
	output logic [63:0]         arg_bytes,
	output logic                eaten,
	output logic                last
);

	localparam int N   = mpksm_pkg::NUM_ENTRIES;
	localparam int CAP = mpksm_pkg::CAPTURE_BYTES;

	// latched item
	logic [1:0] cmd_q;
	logic [7:0] key_q;
	logic [3:0] ei_q;
	logic [4:0] bi_q;
	logic [5:0] len_in_q;
	logic [7:0] games_q;
	logic       anyg_q;

	// entry table
	logic [mpksm_pkg::LEN_W-1:0] len_q  [N];
	logic [7:0]                  mask_q [N];
	logic                        any_q  [N];
	logic [mpksm_pkg::POS_W-1:0] pos_q  [N];

	// capture buffer
	logic [7:0]                   cap_q [CAP];
	logic [mpksm_pkg::FILL_W-1:0] fill_q;
	logic                         eat_q;

	// result register
	logic        out_valid_q;
	logic        kind_q;
	logic [3:0]  idx_q;
	logic [3:0]  cnt_q;
	logic [63:0] bytes_q;
	logic        eaten_q;
	logic        last_q;

	logic                            ei_ok;
	logic                            bi_ok;
	logic [mpksm_pkg::LEN_W-1:0]     len_sat;
	logic                            ram_we;
	logic [mpksm_pkg::PAT_ADDR_W-1:0] ram_waddr;
	logic [mpksm_pkg::PAT_ADDR_W-1:0] ram_raddr;
	logic [7:0]                      pb;
	logic [mpksm_pkg::POS_W-1:0]     pos_iss;
	logic [mpksm_pkg::LEN_W-1:0]     len_c;
	logic [mpksm_pkg::POS_W-1:0]     pos_c;
	logic [mpksm_pkg::LEN_W-1:0]     pos_inc;
	logic                            en_c;
	logic                            wild;
	logic                            hit;
	logic                            last_pos;
	logic                            fire;
	logic                            cap_wr;
	logic [mpksm_pkg::POS_W-1:0]     pos_nxt;
	logic [mpksm_pkg::FILL_W-1:0]    fill_nxt;
	logic [63:0]                     packed_nxt;
	logic [mpksm_pkg::IDX_W-1:0]     ei_idx;

	// table command decode
	assign ei_ok   = (32'(ei_q) < N);
	assign bi_ok   = (32'(bi_q) < mpksm_pkg::MAX_PATTERN_LEN);
	assign len_sat = (32'(len_in_q) > mpksm_pkg::MAX_PATTERN_LEN) ?
		mpksm_pkg::LEN_W'(mpksm_pkg::MAX_PATTERN_LEN) : mpksm_pkg::LEN_W'(len_in_q);
	assign ei_idx  = mpksm_pkg::IDX_W'(ei_q);

	// pattern memory ports
	assign ram_we    = cmd.table_wr && (cmd_q == mpksm_pkg::CMD_WRITE) && ei_ok && bi_ok;
	assign ram_waddr = {ei_idx, mpksm_pkg::POS_W'(bi_q)};
	assign pos_iss   = (mpksm_pkg::LEN_W'(pos_q[cmd.issue_idx]) >= len_q[cmd.issue_idx]) ?
		'0 : pos_q[cmd.issue_idx];
	assign ram_raddr = {cmd.issue_idx, pos_iss};

	mpksm_ram #(
		.WIDTH  (8),
		.DEPTH  (mpksm_pkg::PAT_DEPTH),
		.ADDR_W (mpksm_pkg::PAT_ADDR_W)
	) u_pat_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (key_q),
		.re    (cmd.issue),
		.raddr (ram_raddr),
		.rdata (pb)
	);

	// compare stage
	always_comb begin
		len_c    = len_q[cmd.cmp_idx];
		en_c     = (len_c != '0) && (all_enable || any_q[cmd.cmp_idx] ||
			((mask_q[cmd.cmp_idx] & game_mask) != 8'h00));
		pos_c    = (mpksm_pkg::LEN_W'(pos_q[cmd.cmp_idx]) >= len_c) ? '0 : pos_q[cmd.cmp_idx];
		pos_inc  = mpksm_pkg::LEN_W'(pos_c) + 1'b1;
		wild     = (pb == mpksm_pkg::WILDCARD);
		hit      = en_c && ((pb == key_q) || wild);
		last_pos = (pos_inc >= len_c);
		fire     = hit && last_pos;
		pos_nxt  = (hit && !last_pos) ? pos_inc[mpksm_pkg::POS_W-1:0] : '0;
		cap_wr   = cmd.cmp && hit && wild && (32'(fill_q) < CAP);
		fill_nxt = fill_q + mpksm_pkg::FILL_W'(cap_wr);
	end

	// capture buffer after this compare, packed for the result
	always_comb begin
		packed_nxt = '0;
		for (int k = 0; k < CAP; k++) begin
			if (cap_wr && (fill_q[mpksm_pkg::CAP_IDX_W-1:0] == mpksm_pkg::CAP_IDX_W'(k))) begin
				packed_nxt[8*k +: 8] = key_q;
			end else begin
				packed_nxt[8*k +: 8] = cap_q[k];
			end
		end
	end

	// status
	assign sts.is_key   = (cmd_q == mpksm_pkg::CMD_KEY);
	assign sts.fire     = fire;
	assign sts.out_full = out_valid_q && !out_ready;

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q    <= command;
			key_q    <= key_or_byte;
			ei_q     <= entry_index;
			bi_q     <= byte_index;
			len_in_q <= entry_length;
			games_q  <= entry_games;
			anyg_q   <= entry_any_game;
		end
	end

	// entry table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < N; e++) begin
				len_q[e]  <= '0;
				mask_q[e] <= '0;
				any_q[e]  <= 1'b0;
				pos_q[e]  <= '0;
			end
		end else begin
			for (int e = 0; e < N; e++) begin
				if (cmd.table_wr) begin
					unique case (cmd_q)
						mpksm_pkg::CMD_CLEAR: begin
							len_q[e]  <= '0;
							mask_q[e] <= '0;
							any_q[e]  <= 1'b0;
							pos_q[e]  <= '0;
						end
						mpksm_pkg::CMD_ATTR: begin
							if (ei_ok && (ei_idx == mpksm_pkg::IDX_W'(e))) begin
								len_q[e]  <= len_sat;
								mask_q[e] <= games_q;
								any_q[e]  <= anyg_q;
								pos_q[e]  <= '0;
							end
						end
						default: begin
						end
					endcase
				end else if (cmd.cmp && en_c && (cmd.cmp_idx == mpksm_pkg::IDX_W'(e))) begin
					pos_q[e] <= pos_nxt;
				end
			end
		end
	end

	// capture buffer and eaten flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CAP; k++) begin
				cap_q[k] <= '0;
			end
			fill_q <= '0;
			eat_q  <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				eat_q <= 1'b0;
			end else if (cmd.cmp && hit) begin
				eat_q <= 1'b1;
			end
			if (cmd.cmp && fire) begin
				for (int k = 0; k < CAP; k++) begin
					cap_q[k] <= '0;
				end
				fill_q <= '0;
			end else if (cap_wr) begin
				cap_q[fill_q[mpksm_pkg::CAP_IDX_W-1:0]] <= key_q;
				fill_q <= fill_nxt;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.cmp && fire) || cmd.ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.cmp && fire) begin
			kind_q  <= 1'b0;
			idx_q   <= 4'(cmd.cmp_idx);
			cnt_q   <= 4'(fill_nxt);
			bytes_q <= packed_nxt;
			eaten_q <= 1'b1;
			last_q  <= 1'b0;
		end else if (cmd.ack) begin
			kind_q  <= 1'b1;
			idx_q   <= '0;
			cnt_q   <= '0;
			bytes_q <= '0;
			eaten_q <= eat_q;
			last_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign fired_index = idx_q;
	assign arg_count   = cnt_q;
	assign arg_bytes   = bytes_q;
	assign eaten       = eaten_q;
	assign last        = last_q;

endmodule

/* sv/multi_pattern_key_sequence_matcher_unit.sv */
// Top level: a key item walks the entries one per cycle through the pattern memory read port,
// unless the scan is stalled; the next item is taken only once the final result has been issued.
// A table item is written in the decode state and then gives its acknowledge as a result.
// A completed pattern stalls the scan for as long as the result register is still held.
// Reset (arst_n low, asynchronous) clears entries, match positions, capture buffer, result valid and
// configuration registers; the pattern memory is not cleared and reads as unknown until written.
module multi_pattern_key_sequence_matcher_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic [7:0]                     key_or_byte,
	input  logic [3:0]                     entry_index,
	input  logic [4:0]                     byte_index,
	input  logic [5:0]                     entry_length,
	input  logic [7:0]                     entry_games,
	input  logic                           entry_any_game,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           kind,
	output logic [3:0]                     fired_index,
	output logic [3:0]                     arg_count,
	output logic [63:0]                    arg_bytes,
	output logic                           eaten,
	output logic                           last,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mpksm_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	logic [7:0] game_mask_q;
	logic       all_enable_q;
	logic       reg_sel;
	logic       reg_wr;

	mpksm_pkg::dp_cmd_t dp_cmd;
	mpksm_pkg::dp_sts_t dp_sts;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			game_mask_q  <= '0;
			all_enable_q <= 1'b0;
		end else if (reg_wr) begin
			unique case (reg_sel)
				mpksm_pkg::REG_GAME_MASK:  game_mask_q  <= pwdata[7:0];
				mpksm_pkg::REG_ALL_ENABLE: all_enable_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_sel)
			mpksm_pkg::REG_GAME_MASK:  prdata = {24'h000000, game_mask_q};
			mpksm_pkg::REG_ALL_ENABLE: prdata = {31'h00000000, all_enable_q};
			default:                   prdata = '0;
		endcase
	end

	mpksm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	mpksm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.sts            (dp_sts),
		.command        (command),
		.key_or_byte    (key_or_byte),
		.entry_index    (entry_index),
		.byte_index     (byte_index),
		.entry_length   (entry_length),
		.entry_games    (entry_games),
		.entry_any_game (entry_any_game),
		.game_mask      (game_mask_q),
		.all_enable     (all_enable_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.fired_index    (fired_index),
		.arg_count      (arg_count),
		.arg_bytes      (arg_bytes),
		.eaten          (eaten),
		.last           (last)
	);

endmodule
